// File: rtl/mdiv_pkg.sv
// Shared types, widths and the radix-4 division step for the scaled quotient unit.
`default_nettype none

package mdiv_pkg;

  // Word widths
  localparam int BASE_W = 64;
  localparam int MUL_W  = 32;
  localparam int DIV_W  = 32;
  localparam int QUOT_W = 64;
  localparam int PROD_W = BASE_W + MUL_W;

  // Quotient bits resolved per pipeline stage
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUOT_W / BITS_PER_STAGE;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Partial remainder, dividend bits still to shift in (quotient bits fill from the bottom), divisor, status
  typedef struct packed {
    logic [DIV_W-1:0]  rem;
    logic [QUOT_W-1:0] acc;
    logic [DIV_W-1:0]  dsr;
    status_t           st;
  } div_word_t;

  // Restoring division: BITS_PER_STAGE steps; rem < dsr keeps each step to one subtract
  function automatic div_word_t div_step(input div_word_t w);
    div_word_t      r;
    logic [DIV_W:0] t;
    r = w;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      t     = {r.rem, r.acc[QUOT_W-1]};
      r.acc = {r.acc[QUOT_W-2:0], 1'b0};
      if (t >= {1'b0, r.dsr}) begin
        t        = t - {1'b0, r.dsr};
        r.acc[0] = 1'b1;
      end
      r.rem = t[DIV_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mul_div_64x32_by_32_top.sv
// Top level: pipelined 64x32 multiply followed by 96/32 long division.
// Pipeline: done rises once the word taken with start has passed the multiply stage,
//   the product/check stage, the 32 division stages and the output register.
// Throughput: one word per cycle; busy is never raised, as the pipeline has no stall.
// The 32 division stages each resolve two quotient bits with two 33-bit subtracts.
// Reset (rst, synchronous) clears every valid bit and done; no words are in flight after it.
`default_nettype none

module mul_div_64x32_by_32_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [mdiv_pkg::BASE_W-1:0] dividend_base,
  input  wire logic [mdiv_pkg::MUL_W-1:0]  multiplier,
  input  wire logic [mdiv_pkg::DIV_W-1:0]  divisor,
  output logic                             done,
  output logic [mdiv_pkg::QUOT_W-1:0]      quotient,
  output logic [1:0]                       status
);

  localparam int LATENCY = mdiv_pkg::DIV_STAGES + 3;

  // Input handshake: never stalls
  logic take;
  assign busy = 1'b0;
  assign take = start && !busy;

  // Stage A: two 32x32 partial products
  logic                       a_vld;
  logic [63:0]                a_plo;
  logic [63:0]                a_phi;
  logic [mdiv_pkg::DIV_W-1:0] a_dsr;
  logic [63:0]                plo_next;
  logic [63:0]                phi_next;

  assign plo_next = 64'(dividend_base[31:0]) * 64'(multiplier);
  assign phi_next = 64'(dividend_base[63:32]) * 64'(multiplier);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= take;
    end
  end

  always_ff @(posedge clk) begin
    a_plo <= plo_next;
    a_phi <= phi_next;
    a_dsr <= divisor;
  end

  // Stage B: middle-word sum with carry kept, zero-divisor and overflow checks
  logic                 b_vld;
  mdiv_pkg::div_word_t  b_word;
  mdiv_pkg::div_word_t  b_word_next;
  logic [63:0]          mid_sum;

  assign mid_sum = a_phi + {32'd0, a_plo[63:32]};

  always_comb begin
    b_word_next.rem = mid_sum[63:32];
    b_word_next.acc = {mid_sum[31:0], a_plo[31:0]};
    b_word_next.dsr = a_dsr;
    if (a_dsr == '0) begin
      b_word_next.st = mdiv_pkg::ST_DIV_ZERO;
    end else if (mid_sum[63:32] >= a_dsr) begin
      b_word_next.st = mdiv_pkg::ST_OVERFLOW;
    end else begin
      b_word_next.st = mdiv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_word <= b_word_next;
  end

  // Division pipeline: two quotient bits per stage
  logic [mdiv_pkg::DIV_STAGES:0] dv;
  mdiv_pkg::div_word_t           dw [mdiv_pkg::DIV_STAGES+1];

  assign dv[0] = b_vld;
  assign dw[0] = b_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[mdiv_pkg::DIV_STAGES:1] <= '0;
    end else begin
      dv[mdiv_pkg::DIV_STAGES:1] <= dv[mdiv_pkg::DIV_STAGES-1:0];
    end
  end

  for (genvar s = 0; s < mdiv_pkg::DIV_STAGES; s++) begin : g_div
    always_ff @(posedge clk) begin
      dw[s+1] <= mdiv_pkg::div_step(dw[s]);
    end
  end

  // Output register: quotient forced to zero on any error
  mdiv_pkg::div_word_t last_word;
  mdiv_pkg::status_t   status_q;

  assign last_word = dw[mdiv_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[mdiv_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    status_q <= last_word.st;
    quotient <= (last_word.st == mdiv_pkg::ST_OK) ? last_word.acc : '0;
  end

  assign status = status_q;

  // Checks
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    take |-> ##LATENCY done)
    else $error("accepted word did not come out after the pipeline latency");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, LATENCY))
    else $error("result strobe without a matching accepted word");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status_q != mdiv_pkg::ST_OK) |-> quotient == '0)
    else $error("error result carries a nonzero quotient");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    b_vld && (b_word.st == mdiv_pkg::ST_OK) |-> b_word.rem < b_word.dsr)
    else $error("top product word not below divisor on an accepted division");

  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    a_vld && (a_dsr == '0) |=> b_word.st == mdiv_pkg::ST_DIV_ZERO)
    else $error("zero divisor not flagged");

endmodule

`default_nettype wire

// File: sim/tb_mul_div_64x32_by_32_top.sv
// Testbench for the scaled quotient unit: directed and random words, checked by an own predictor.
module tb_mul_div_64x32_by_32_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [mdiv_pkg::BASE_W-1:0] BASE_MAX = '1;
  localparam logic [mdiv_pkg::MUL_W-1:0]  MUL_MAX  = '1;
  localparam logic [mdiv_pkg::DIV_W-1:0]  DIV_MAX  = '1;
  localparam int                RANDOM_WORDS = 700;
  localparam int                DRAIN_CYCLES = 200;
  localparam int                SETTLE_CYCLES = 40;

  // one expected result word
  typedef struct packed {
    logic [mdiv_pkg::QUOT_W-1:0] q;
    mdiv_pkg::status_t           st;
  } quot_word_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [mdiv_pkg::BASE_W-1:0]   dividend_base = '0;
  logic [mdiv_pkg::MUL_W-1:0]    multiplier = '0;
  logic [mdiv_pkg::DIV_W-1:0]    divisor = '0;
  logic                          done;
  logic [mdiv_pkg::QUOT_W-1:0]   quotient;
  logic [1:0]                    status;

  quot_word_t          pending_quotients[$];
  quot_word_t          head_word;
  int                  mismatch_count = 0;

  mul_div_64x32_by_32_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .dividend_base (dividend_base),
    .multiplier    (multiplier),
    .divisor       (divisor),
    .done          (done),
    .quotient      (quotient),
    .status        (status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // upper 32 bits of the full 96-bit product
  function automatic logic [mdiv_pkg::DIV_W-1:0] product_top(
      input logic [mdiv_pkg::BASE_W-1:0] base,
      input logic [mdiv_pkg::MUL_W-1:0]  mul);
    logic [mdiv_pkg::PROD_W-1:0] prod;
    prod = {{mdiv_pkg::MUL_W{1'b0}}, base} * {{mdiv_pkg::BASE_W{1'b0}}, mul};
    return prod[mdiv_pkg::PROD_W-1 -: mdiv_pkg::DIV_W];
  endfunction

  // floor(base * mul / div), zero divisor checked ahead of overflow
  function automatic quot_word_t scale_divide(input logic [mdiv_pkg::BASE_W-1:0] base,
                                              input logic [mdiv_pkg::MUL_W-1:0]  mul,
                                              input logic [mdiv_pkg::DIV_W-1:0]  div);
    logic [mdiv_pkg::PROD_W-1:0] prod;
    logic [mdiv_pkg::PROD_W-1:0] quo;
    quot_word_t                  r;
    prod = {{mdiv_pkg::MUL_W{1'b0}}, base} * {{mdiv_pkg::BASE_W{1'b0}}, mul};
    r.q  = '0;
    if (div == '0) begin
      r.st = mdiv_pkg::ST_DIV_ZERO;
    end else if (prod[mdiv_pkg::PROD_W-1 -: mdiv_pkg::DIV_W] >= div) begin
      r.st = mdiv_pkg::ST_OVERFLOW;
    end else begin
      quo  = prod / {{(mdiv_pkg::PROD_W-mdiv_pkg::DIV_W){1'b0}}, div};
      r.st = mdiv_pkg::ST_OK;
      r.q  = quo[mdiv_pkg::QUOT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [mdiv_pkg::BASE_W-1:0] rand_base();
    return {$urandom, $urandom};
  endfunction

  // present one word and hold it until taken; start stays high afterwards
  task automatic send_word(input logic [mdiv_pkg::BASE_W-1:0] base,
                           input logic [mdiv_pkg::MUL_W-1:0]  mul,
                           input logic [mdiv_pkg::DIV_W-1:0]  div);
    start         <= 1'b1;
    dividend_base <= base;
    multiplier    <= mul;
    divisor       <= div;
    do @(posedge clk); while (busy);
    pending_quotients.push_back(scale_divide(base, mul, div));
  endtask

  // sender gap: start low, junk on the fields
  task automatic idle_for(input int n);
    repeat (n) begin
      start         <= 1'b0;
      dividend_base <= rand_base();
      multiplier    <= $urandom;
      divisor       <= $urandom;
      @(posedge clk);
    end
  endtask

  // field extremes and exact results, in two back-to-back groups
  task automatic test_field_extremes();
    send_word('0, '0, 32'd1);
    send_word(BASE_MAX, MUL_MAX, DIV_MAX);
    send_word(BASE_MAX, 32'd1, 32'd1);
    send_word('0, MUL_MAX, DIV_MAX);
    send_word(64'd1, 32'd1, DIV_MAX);
    send_word(BASE_MAX, '0, 32'd5);
    send_word(64'h8000_0000_0000_0000, 32'd2, 32'd2);
    send_word(64'h8000_0000_0000_0000, 32'h8000_0000, 32'h8000_0000);
    idle_for(3);
    // long remainders carried into the low digit
    send_word(64'hDEAD_BEEF_0123_4567, 32'h7FFF_FFFF, 32'h8000_0001);
    send_word(64'h0000_0000_FFFF_FFFF, MUL_MAX, 32'hFFFF_FFFE);
    send_word(64'h5555_5555_AAAA_AAAA, 32'h3, 32'h7);
    idle_for(2);
  endtask

  // zero divisor wins over a product that would overflow
  task automatic test_error_precedence();
    send_word(BASE_MAX, MUL_MAX, '0);
    send_word('0, '0, '0);
    send_word(BASE_MAX, MUL_MAX, 32'd1);
    send_word(BASE_MAX, 32'd2, 32'd1);
    idle_for(1);
  endtask

  // divisor equal to the product's top word, then one above it
  task automatic test_overflow_boundary();
    logic [mdiv_pkg::BASE_W-1:0] base;
    logic [mdiv_pkg::MUL_W-1:0]  mul;
    logic [mdiv_pkg::DIV_W-1:0]  top;
    base = 64'h1234_5678_9ABC_DEF0;
    mul  = 32'hFEDC_BA98;
    top  = product_top(base, mul);
    send_word(base, mul, top);
    send_word(base, mul, top + 32'd1);
    repeat (2) begin
      base = rand_base();
      mul  = $urandom;
      top  = product_top(base, mul);
      send_word(base, mul, top);
      if (top != DIV_MAX) begin
        send_word(base, mul, top + 32'd1);
      end
    end
    idle_for(4);
  endtask

  // bursts of random words, most of them fitted to give a valid quotient
  task automatic test_random_scaling();
    logic [mdiv_pkg::BASE_W-1:0] base;
    logic [mdiv_pkg::MUL_W-1:0]  mul;
    logic [mdiv_pkg::DIV_W-1:0]  div;
    logic [mdiv_pkg::DIV_W-1:0]  top;
    int                          sent;
    int                          burst;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      repeat (burst) begin
        case ($urandom_range(0, 7))
          0:       base = {32'd0, $urandom};
          1:       base = BASE_MAX;
          default: base = rand_base();
        endcase
        case ($urandom_range(0, 11))
          0:       mul = '0;
          1:       mul = 32'd1;
          2:       mul = MUL_MAX;
          default: mul = $urandom;
        endcase
        top = product_top(base, mul);
        case ($urandom_range(0, 9))
          6:       div = top;
          7:       div = '0;
          8:       div = $urandom_range(1, 255);
          9:       div = $urandom;
          default: div = (top != DIV_MAX) ? $urandom_range(DIV_MAX, top + 32'd1) : $urandom;
        endcase
        send_word(base, mul, div);
        sent++;
      end
      if ($urandom_range(0, 5) != 0) begin
        idle_for($urandom_range(1, 8));
      end
    end
    idle_for(1);
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_quotients.size() == 0) begin
        $display("%0t: unexpected word: quotient %h status %0d", $time, quotient, status);
        mismatch_count++;
      end else begin
        head_word = pending_quotients.pop_front();
        if (quotient !== head_word.q) begin
          $display("%0t: quotient expected %h actual %h", $time, head_word.q, quotient);
          mismatch_count++;
        end
        if (status !== head_word.st) begin
          $display("%0t: status expected %0d actual %0d", $time, head_word.st, status);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_error_precedence();
    test_overflow_boundary();
    test_random_scaling();
    waited = 0;
    while (pending_quotients.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    if (pending_quotients.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_quotients.size());
      mismatch_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200us;
    $display("tb: failure");
    $finish;
  end

endmodule
